### hdl/keyed_max_tracking_table_top_defines.svh
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef KEYED_MAX_TRACKING_TABLE_TOP_DEFINES_SVH
`define KEYED_MAX_TRACKING_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KMTT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define KMTT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/kmtt_pkg.sv
`default_nettype none

package kmtt_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 64;
    localparam int MODE_W  = 2;
    localparam int FOLD_W  = 16;

    // Mode field operation codes. The fourth only yields a zero result.
    typedef enum logic [MODE_W-1:0] {
        MODE_UPDATE = 2'd0,
        MODE_PROBE  = 2'd1,
        MODE_CLEAR  = 2'd2
    } mode_t;

    // One table slot as it sits in the RAM word.
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_RESP
    } state_t;

    // Verdict of one item.
    typedef struct packed {
        logic accepted;
        logic key_found;
        logic table_full;
    } result_t;

endpackage

`default_nettype wire

### hdl/kmtt_ram.sv
`default_nettype none

module kmtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/keyed_max_tracking_table_top.sv
// Channel | Ports                                   | Beat meaning
// input   | s_valid s_ready s_mode s_key s_new_value| one update, probe or clear
// result  | m_valid m_ready m_accepted m_key_found  | one verdict per input beat
//         | m_table_full                            |
//
// Update and probe visit P slots by linear probing (at least 1), then load the
// result; each visit is one RAM read and one compare.
// A clear loads its result and then runs a sweep over all ENTRIES slots that empties the RAM.
// After reset the same sweep runs before the first beat is taken.
// A stalled result register holds the sequencer until the result is taken.
`default_nettype none

`include "keyed_max_tracking_table_top_defines.svh"

module keyed_max_tracking_table_top #(
    parameter int ENTRIES = 256
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic        [kmtt_pkg::MODE_W-1:0]  s_mode,
    input  wire logic signed [kmtt_pkg::KEY_W-1:0]   s_key,
    input  wire logic signed [kmtt_pkg::VALUE_W-1:0] s_new_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_accepted,
    output logic                                   m_key_found,
    output logic                                   m_table_full
);

    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int MUL_W  = 2 * kmtt_pkg::FOLD_W + 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(ENTRIES);
    localparam logic [CNT_W-1:0]  LAST_PROBE = CNT_W'(ENTRIES - 1);

    kmtt_pkg::state_t state_reg, state_next;
    logic [SLOT_W-1:0] sweep_reg, sweep_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  probes_reg, probes_next;
    logic              m_valid_reg, m_valid_next;

    // Payload registers of the item in flight and of the result.
    logic [SLOT_W-1:0]            slot_reg, slot_next;
    logic [kmtt_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [kmtt_pkg::VALUE_W-1:0] value_reg, value_next;
    logic                         update_reg, update_next;
    logic                         clear_reg, clear_next;
    kmtt_pkg::result_t            res_reg, res_next;
    kmtt_pkg::result_t            out_reg, out_next;

    logic                         in_beat;
    logic                         out_free;
    logic                         out_load;
    logic [kmtt_pkg::FOLD_W-1:0]  fold;
    logic [MUL_W-1:0]             home_prod;
    logic [SLOT_W-1:0]            home_slot;
    logic [SLOT_W-1:0]            slot_step;

    logic                         ram_wr_en;
    logic [SLOT_W-1:0]            ram_wr_addr;
    kmtt_pkg::entry_t             ram_wr_entry;
    logic                         ram_rd_en;
    logic [kmtt_pkg::ENTRY_W-1:0] ram_rd_data;
    kmtt_pkg::entry_t             rd_entry;

    logic                         key_hit;
    logic                         value_better;
    logic                         search_end;
    logic                         no_room;
    logic                         new_entry;

    // Home slot: fold the key to 16 bits and scale it into the slot range.
    assign fold      = s_key[31:16] ^ s_key[15:0] ^ {s_key[7:0], s_key[23:16]};
    assign home_prod = MUL_W'(fold) * MUL_W'(ENTRIES);
    assign home_slot = home_prod[kmtt_pkg::FOLD_W +: SLOT_W];
    assign slot_step = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;

    assign in_beat  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Compare the slot just read against the key in flight.
    assign rd_entry     = kmtt_pkg::entry_t'(ram_rd_data);
    assign key_hit      = rd_entry.valid && (rd_entry.key == key_reg);
    assign value_better = $signed(rd_entry.value) < $signed(value_reg);
    assign search_end   = !rd_entry.valid || (probes_reg == LAST_PROBE);
    assign no_room      = (count_reg == FULL_COUNT);

    // Sequencer: next state, RAM control and result capture.
    always_comb begin
        state_next   = state_reg;
        sweep_next   = sweep_reg;
        count_next   = count_reg;
        probes_next  = probes_reg;
        slot_next    = slot_reg;
        key_next     = key_reg;
        value_next   = value_reg;
        update_next  = update_reg;
        clear_next   = clear_reg;
        res_next     = res_reg;
        s_ready      = 1'b0;
        out_load     = 1'b0;
        ram_rd_en    = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = slot_reg;
        ram_wr_entry = '{valid: 1'b1, key: key_reg, value: value_reg};
        new_entry    = 1'b0;

        unique case (state_reg)
            kmtt_pkg::ST_SWEEP: begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = sweep_reg;
                ram_wr_entry = '0;
                sweep_next   = sweep_reg + 1'b1;
                if (sweep_reg == LAST_SLOT) begin
                    sweep_next = '0;
                    state_next = kmtt_pkg::ST_IDLE;
                end
            end
            kmtt_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    slot_next   = home_slot;
                    key_next    = s_key;
                    value_next  = s_new_value;
                    probes_next = '0;
                    res_next    = '0;
                    update_next = 1'b0;
                    clear_next  = 1'b0;
                    unique case (kmtt_pkg::mode_t'(s_mode))
                        kmtt_pkg::MODE_UPDATE: begin
                            update_next = 1'b1;
                            state_next  = kmtt_pkg::ST_READ;
                        end
                        kmtt_pkg::MODE_PROBE: begin
                            state_next = kmtt_pkg::ST_READ;
                        end
                        kmtt_pkg::MODE_CLEAR: begin
                            clear_next = 1'b1;
                            count_next = '0;
                            state_next = kmtt_pkg::ST_RESP;
                        end
                        default: begin
                            state_next = kmtt_pkg::ST_RESP;
                        end
                    endcase
                end
            end
            kmtt_pkg::ST_READ: begin
                ram_rd_en  = 1'b1;
                state_next = kmtt_pkg::ST_CMP;
            end
            kmtt_pkg::ST_CMP: begin
                priority if (key_hit) begin
                    res_next   = '{accepted: value_better, key_found: 1'b1, table_full: 1'b0};
                    ram_wr_en  = update_reg && value_better;
                    state_next = kmtt_pkg::ST_RESP;
                end else if (search_end) begin
                    res_next   = '{accepted: !no_room, key_found: 1'b0, table_full: no_room};
                    new_entry  = update_reg && !no_room;
                    ram_wr_en  = new_entry;
                    state_next = kmtt_pkg::ST_RESP;
                    if (new_entry) begin
                        count_next = count_reg + 1'b1;
                    end
                end else begin
                    slot_next   = slot_step;
                    probes_next = probes_reg + 1'b1;
                    state_next  = kmtt_pkg::ST_READ;
                end
            end
            kmtt_pkg::ST_RESP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = clear_reg ? kmtt_pkg::ST_SWEEP : kmtt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = kmtt_pkg::ST_IDLE;
            end
        endcase
    end

    // Result register: loaded when free, emptied when the beat is taken.
    always_comb begin
        out_next     = out_load ? res_reg : out_reg;
        m_valid_next = out_load || (m_valid_reg && !m_ready);
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= kmtt_pkg::ST_SWEEP;
            sweep_reg   <= '0;
            count_reg   <= '0;
            probes_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            count_reg   <= count_next;
            probes_reg  <= probes_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload state.
    always_ff @(posedge aclk) begin
        slot_reg   <= slot_next;
        key_reg    <= key_next;
        value_reg  <= value_next;
        update_reg <= update_next;
        clear_reg  <= clear_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    // Slot store: valid flag, key and best value in one word.
    kmtt_ram #(
        .WIDTH (kmtt_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (slot_reg),
        .rd_data (ram_rd_data)
    );

    assign m_valid      = m_valid_reg;
    assign m_accepted   = out_reg.accepted;
    assign m_key_found  = out_reg.key_found;
    assign m_table_full = out_reg.table_full;

    // The fill count never passes the table size.
    `KMTT_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= FULL_COUNT, "entry count overflow")
    // A new key is only written while room is left.
    `KMTT_ASSERT_NOW(a_insert_room, aclk, aresetn, new_entry, count_reg < FULL_COUNT, "insert into full table")
    // A result is never loaded over one that is still waiting.
    `KMTT_ASSERT_NOW(a_no_overwrite, aclk, aresetn, out_load, !m_valid_reg || m_ready, "result beat overwritten")
    // A clear beat empties the registered fill count.
    `KMTT_ASSERT_NEXT(a_clear_count, aclk, aresetn, in_beat && (s_mode == kmtt_pkg::MODE_CLEAR), count_reg == '0, "clear left entries counted")

endmodule

`default_nettype wire
